/* sv/pnghi_pkg.sv */
package pnghi_pkg;

  localparam int unsigned CNT_W = 6;

  localparam logic [CNT_W-1:0] SIG_BYTES       = 6'd8;
  localparam logic [CNT_W-1:0] IDX_LENGTH_END  = 6'd11;
  localparam logic [CNT_W-1:0] CRC_FIRST       = 6'd12;
  localparam logic [CNT_W-1:0] IDX_TYPE_END    = 6'd15;
  localparam logic [CNT_W-1:0] IDX_WIDTH_END   = 6'd19;
  localparam logic [CNT_W-1:0] IDX_HEIGHT_END  = 6'd23;
  localparam logic [CNT_W-1:0] IDX_SMALL_FIRST = 6'd24;
  localparam logic [CNT_W-1:0] CRC_LAST        = 6'd28;
  localparam logic [CNT_W-1:0] HDR_BYTES       = 6'd33;

  localparam logic [31:0] IHDR_LENGTH = 32'd13;
  localparam logic [31:0] TYPE_IHDR   = 32'h4948_4452;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

  localparam logic [7:0] COLOR_GRAY       = 8'd0;
  localparam logic [7:0] COLOR_RGB        = 8'd2;
  localparam logic [7:0] COLOR_PALETTE    = 8'd3;
  localparam logic [7:0] COLOR_GRAY_ALPHA = 8'd4;
  localparam logic [7:0] COLOR_RGBA       = 8'd6;

  localparam logic [7:0] ILACE_MAX = 8'd1;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_EMPTY       = 4'd1;
  localparam logic [3:0] ST_SHORT       = 4'd2;
  localparam logic [3:0] ST_SIGNATURE   = 4'd3;
  localparam logic [3:0] ST_LENGTH      = 4'd4;
  localparam logic [3:0] ST_TYPE        = 4'd5;
  localparam logic [3:0] ST_ZERO_SIZE   = 4'd6;
  localparam logic [3:0] ST_COMPRESSION = 4'd7;
  localparam logic [3:0] ST_FILTER      = 4'd8;
  localparam logic [3:0] ST_INTERLACE   = 4'd9;
  localparam logic [3:0] ST_CRC         = 4'd10;
  localparam logic [3:0] ST_COLOR       = 4'd11;
  localparam logic [3:0] ST_DEPTH       = 4'd12;

  localparam logic CFG_IDX_CRC_BYPASS = 1'b0;

  typedef struct packed {
    logic [3:0]  pad;
    logic [7:0]  interlace_mode;
    logic [7:0]  color_kind;
    logic [7:0]  bit_depth;
    logic [31:0] image_height;
    logic [31:0] image_width;
    logic [3:0]  status;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] v;
    unique case (i)
      3'd0:    v = 8'd137;
      3'd1:    v = 8'd80;
      3'd2:    v = 8'd78;
      3'd3:    v = 8'd71;
      3'd4:    v = 8'd13;
      3'd5:    v = 8'd10;
      3'd6:    v = 8'd26;
      3'd7:    v = 8'd10;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [3:0] pair_status(input logic [7:0] ct, input logic [7:0] bd);
    logic [3:0] st;
    case (ct) inside
      COLOR_GRAY:
        st = (bd == 8'd1 || bd == 8'd2 || bd == 8'd4 || bd == 8'd8 || bd == 8'd16)
             ? ST_OK : ST_DEPTH;
      COLOR_PALETTE:
        st = (bd == 8'd1 || bd == 8'd2 || bd == 8'd4 || bd == 8'd8) ? ST_OK : ST_DEPTH;
      COLOR_RGB, COLOR_GRAY_ALPHA, COLOR_RGBA:
        st = (bd == 8'd8 || bd == 8'd16) ? ST_OK : ST_DEPTH;
      default:
        st = ST_COLOR;
    endcase
    return st;
  endfunction

endpackage

/* sv/png_header_inspector_top.sv */
// PNG header inspector.
// Input stream: one file byte per transfer in in_tdata[7:0]; in_tuser high
// marks a real byte (low only on an empty end marker); in_tlast ends the file.
// Output stream: one result per file in out_tdata (status, width, height,
// depth, colour type, interlace), given when header byte 33 arrives or at an
// earlier end of file. Bytes after the header are dropped until in_tlast.
// Config: APB register 0 at address 0, bit 0 = crc_bypass (skip CRC check).
// Throughput: one byte per cycle while in_tready is high; the CRC-32 takes a whole byte per cycle.
// Latency: the result is valid in the cycle after the transfer of the byte
// (or end marker) that completes it.
// Stall: a single output register holds a pending result; in_tready stays
// high while that register is empty or being read, and drops only while a
// result waits with out_tready low.
// Reset (synchronous, rst_n low): parser state, the output valid flag and
// crc_bypass clear at once (out_tdata is not reset); the block is ready in the next cycle.
module png_header_inspector_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] status, [35:4] image_width, [67:36] image_height,
  // [75:68] bit_depth, [83:76] color_kind, [91:84] interlace_mode
  output logic [95:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                           crc_bypass_r;
  logic [pnghi_pkg::CNT_W-1:0]    byte_count_r, byte_count_nxt;
  logic                           header_done_r, header_done_nxt;
  logic                           signature_ok_r, signature_ok_nxt;
  logic [31:0]                    field_shift_r, field_shift_nxt;
  logic [31:0]                    chunk_length_r, chunk_length_nxt;
  logic [31:0]                    chunk_tag_r, chunk_tag_nxt;
  logic [31:0]                    width_hold_r, width_hold_nxt;
  logic [31:0]                    height_hold_r, height_hold_nxt;
  logic [39:0]                    small_fields_r, small_fields_nxt;
  logic [31:0]                    crc_running_r, crc_running_nxt;
  logic                           out_valid_r, out_valid_nxt;
  pnghi_pkg::result_t             out_data_r, out_data_nxt;

  logic                           in_fire, out_fire, cfg_write;
  logic                           emit;
  logic [pnghi_pkg::CNT_W-1:0]    idx;
  logic [7:0]                     byte_v;
  logic [7:0]                     depth, ctype, comp, filt, ilace;
  logic [3:0]                     st;

  assign in_fire    = in_tvalid & in_tready;
  assign out_fire   = out_valid_r & out_tready;
  assign in_tready  = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == pnghi_pkg::CFG_IDX_CRC_BYPASS)
                      ? {31'd0, crc_bypass_r} : 32'd0;

  assign byte_v = in_tdata;
  assign idx    = byte_count_r;
  assign depth  = small_fields_r[39:32];
  assign ctype  = small_fields_r[31:24];
  assign comp   = small_fields_r[23:16];
  assign filt   = small_fields_r[15:8];
  assign ilace  = small_fields_r[7:0];

  always_comb begin
    byte_count_nxt   = byte_count_r;
    header_done_nxt  = header_done_r;
    signature_ok_nxt = signature_ok_r;
    field_shift_nxt  = field_shift_r;
    chunk_length_nxt = chunk_length_r;
    chunk_tag_nxt    = chunk_tag_r;
    width_hold_nxt   = width_hold_r;
    height_hold_nxt  = height_hold_r;
    small_fields_nxt = small_fields_r;
    crc_running_nxt  = crc_running_r;
    emit             = 1'b0;
    out_data_nxt     = '0;
    st               = pnghi_pkg::ST_OK;

    if (in_fire) begin
      if (in_tuser && !header_done_r) begin
        if (idx < pnghi_pkg::SIG_BYTES && byte_v != pnghi_pkg::sig_byte(idx[2:0])) begin
          signature_ok_nxt = 1'b0;
        end
        field_shift_nxt = {field_shift_r[23:0], byte_v};
        if (idx >= pnghi_pkg::CRC_FIRST && idx <= pnghi_pkg::CRC_LAST) begin
          crc_running_nxt = pnghi_pkg::crc_byte(crc_running_r, byte_v);
        end
        if (idx == pnghi_pkg::IDX_LENGTH_END) chunk_length_nxt = field_shift_nxt;
        if (idx == pnghi_pkg::IDX_TYPE_END)   chunk_tag_nxt    = field_shift_nxt;
        if (idx == pnghi_pkg::IDX_WIDTH_END)  width_hold_nxt   = field_shift_nxt;
        if (idx == pnghi_pkg::IDX_HEIGHT_END) height_hold_nxt  = field_shift_nxt;
        if (idx >= pnghi_pkg::IDX_SMALL_FIRST && idx <= pnghi_pkg::CRC_LAST) begin
          small_fields_nxt = {small_fields_r[31:0], byte_v};
        end
        byte_count_nxt = idx + 6'd1;

        if (byte_count_nxt == pnghi_pkg::HDR_BYTES) begin
          emit            = 1'b1;
          header_done_nxt = 1'b1;
          if (width_hold_r == 32'd0 || height_hold_r == 32'd0) begin
            st = pnghi_pkg::ST_ZERO_SIZE;
          end else if (comp != 8'd0) begin
            st = pnghi_pkg::ST_COMPRESSION;
          end else if (filt != 8'd0) begin
            st = pnghi_pkg::ST_FILTER;
          end else if (ilace > pnghi_pkg::ILACE_MAX) begin
            st = pnghi_pkg::ST_INTERLACE;
          end else if (!crc_bypass_r && field_shift_nxt != ~crc_running_r) begin
            st = pnghi_pkg::ST_CRC;
          end else begin
            st = pnghi_pkg::pair_status(ctype, depth);
          end

          if (!signature_ok_r) begin
            out_data_nxt.status = pnghi_pkg::ST_SIGNATURE;
          end else if (chunk_length_r != pnghi_pkg::IHDR_LENGTH) begin
            out_data_nxt.status = pnghi_pkg::ST_LENGTH;
          end else if (chunk_tag_r != pnghi_pkg::TYPE_IHDR) begin
            out_data_nxt.status = pnghi_pkg::ST_TYPE;
          end else begin
            out_data_nxt.status         = st;
            out_data_nxt.image_width    = width_hold_r;
            out_data_nxt.image_height   = height_hold_r;
            out_data_nxt.bit_depth      = depth;
            out_data_nxt.color_kind     = ctype;
            out_data_nxt.interlace_mode = ilace;
          end
        end
      end

      if (in_tlast) begin
        if (!header_done_nxt) begin
          emit         = 1'b1;
          out_data_nxt = '0;
          out_data_nxt.status = (byte_count_nxt == '0) ? pnghi_pkg::ST_EMPTY
                                                       : pnghi_pkg::ST_SHORT;
        end
        byte_count_nxt   = '0;
        header_done_nxt  = 1'b0;
        signature_ok_nxt = 1'b1;
        field_shift_nxt  = '0;
        chunk_length_nxt = '0;
        chunk_tag_nxt    = '0;
        width_hold_nxt   = '0;
        height_hold_nxt  = '0;
        small_fields_nxt = '0;
        crc_running_nxt  = pnghi_pkg::CRC_INIT;
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_bypass_r   <= 1'b0;
      byte_count_r   <= '0;
      header_done_r  <= 1'b0;
      signature_ok_r <= 1'b1;
      field_shift_r  <= '0;
      chunk_length_r <= '0;
      chunk_tag_r    <= '0;
      width_hold_r   <= '0;
      height_hold_r  <= '0;
      small_fields_r <= '0;
      crc_running_r  <= pnghi_pkg::CRC_INIT;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_write && cfg_paddr[2] == pnghi_pkg::CFG_IDX_CRC_BYPASS) begin
        crc_bypass_r <= cfg_pwdata[0];
      end
      byte_count_r   <= byte_count_nxt;
      header_done_r  <= header_done_nxt;
      signature_ok_r <= signature_ok_nxt;
      field_shift_r  <= field_shift_nxt;
      chunk_length_r <= chunk_length_nxt;
      chunk_tag_r    <= chunk_tag_nxt;
      width_hold_r   <= width_hold_nxt;
      height_hold_r  <= height_hold_nxt;
      small_fields_r <= small_fields_nxt;
      crc_running_r  <= crc_running_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_done_at_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    header_done_r |-> byte_count_r == pnghi_pkg::HDR_BYTES)
    else $error("header_done set with byte count other than the header length");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= pnghi_pkg::HDR_BYTES)
    else $error("byte count ran past the header");

  a_sig_fail_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    !signature_ok_r |-> byte_count_r != '0)
    else $error("signature failure with no bytes seen");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> byte_count_r == '0 && !header_done_r
                            && crc_running_r == pnghi_pkg::CRC_INIT)
    else $error("end of file did not restart the parser");

  a_header_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser && !header_done_r
      && byte_count_r == pnghi_pkg::HDR_BYTES - 6'd1
    |=> out_tvalid)
    else $error("final header byte gave no result");

endmodule
